// ===== hw/rtl/afd_pkg.sv =====
`default_nettype none

package afd_pkg;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int RAW_W   = 12;
    localparam int SCALE_W = 16;
    localparam int ACCEL_W = 28;
    localparam int POS_W   = 3;

    // Full width of a raw axis times the zero-extended scale.
    localparam int PROD_W  = RAW_W + SCALE_W + 1;

    // The buffer holds the first five sample bytes; the sixth arrives with the last beat.
    localparam int SAMPLE_COUNT = 5;

    // Frame constants.
    localparam logic [BYTE_W-1:0]  HEADER_BYTE = 8'h48;
    localparam logic [BYTE_W-1:0]  FLAG_ON     = 8'h01;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd628;

    // Position within a frame.
    localparam logic [POS_W-1:0] POS_HEADER  = 3'd0;
    localparam logic [POS_W-1:0] POS_FLAG    = 3'd1;
    localparam logic [POS_W-1:0] POS_SAMPLE0 = 3'd2;
    localparam logic [POS_W-1:0] POS_LAST    = 3'd7;

    // One decoded frame, handed from the parser to the scaler.
    typedef struct packed {
        logic              enabled;
        logic [RAW_W-1:0]  x_raw;
        logic [RAW_W-1:0]  y_raw;
        logic [RAW_W-1:0]  z_raw;
    } afd_frame_t;

endpackage

`default_nettype wire

// ===== hw/rtl/accel_frame_decoder_unit.sv =====
// Accelerometer frame decoder.
// The s_ channel carries received serial bytes, one per beat. A frame is the
// header byte 'H', an enable flag byte and six sample bytes (low/high pairs for
// X, Y and Z); bytes outside a frame other than the header are dropped.
// On the last byte of a frame one beat appears on the m_ channel: the three
// 12-bit axes times scale_q16 (Q16), or zeros with m_sensor_enabled low when
// the flag byte is not 1.
// Throughput: one byte per cycle while s_ready is high, so at most one result
// per frame. After the last byte is accepted the result passes through the
// frame register and then the multiplier result register. The user must write
// the scale register through cfg_wr_en/cfg_wr_data only while idle; the block
// does not enforce this. When the receiver stalls, the result register holds
// its beat and the frame register absorbs one more frame; s_ready falls only
// once both are full. Synchronous active-low reset returns to waiting for a
// header, clears the flag, empties both registers and sets the scale to 628.
`default_nettype none

module accel_frame_decoder_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [afd_pkg::SCALE_W-1:0]       cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [afd_pkg::BYTE_W-1:0]        s_rx_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [afd_pkg::ACCEL_W-1:0]     m_x_accel,
    output logic signed [afd_pkg::ACCEL_W-1:0]     m_y_accel,
    output logic signed [afd_pkg::ACCEL_W-1:0]     m_z_accel,
    output logic                                   m_sensor_enabled
);
    import afd_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic               frame_valid;
    logic               frame_ready;
    afd_frame_t         frame;

    // Scale configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
        end else if (cfg_wr_en) begin
            scale_reg <= cfg_wr_data;
        end
    end

    afd_frame_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_ready (frame_ready)
    );

    afd_axis_scaler u_scaler (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .frame_valid      (frame_valid),
        .frame            (frame),
        .frame_ready      (frame_ready),
        .scale_q16        (scale_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_x_accel        (m_x_accel),
        .m_y_accel        (m_y_accel),
        .m_z_accel        (m_z_accel),
        .m_sensor_enabled (m_sensor_enabled)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/afd_frame_parser.sv =====
`default_nettype none

module afd_frame_parser (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [afd_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                               frame_valid,
    output afd_pkg::afd_frame_t                frame,
    input  wire logic                          frame_ready
);
    import afd_pkg::*;

    logic [POS_W-1:0]  position_reg, position_next;
    logic [BYTE_W-1:0] enable_reg, enable_next;
    logic              frame_valid_reg, frame_valid_next;
    afd_frame_t        frame_reg, frame_next;
    logic [BYTE_W-1:0] sample_reg [SAMPLE_COUNT];

    logic              accept;
    logic              sample_write;
    logic [POS_W-1:0]  sample_idx;

    // A new beat is taken whenever the frame register is empty or being drained.
    assign s_ready = !frame_valid_reg || frame_ready;
    assign accept  = s_valid && s_ready;

    assign sample_idx = position_reg - POS_SAMPLE0;

    // Frame sequencing and assembly of the decoded frame on the last beat.
    always_comb begin
        position_next    = position_reg;
        enable_next      = enable_reg;
        frame_valid_next = frame_valid_reg && !frame_ready;
        frame_next       = frame_reg;
        sample_write     = 1'b0;
        if (accept) begin
            case (position_reg)
                POS_HEADER: begin
                    if (s_rx_byte == HEADER_BYTE) begin
                        position_next = POS_FLAG;
                    end
                end
                POS_FLAG: begin
                    enable_next   = s_rx_byte;
                    position_next = POS_SAMPLE0;
                end
                POS_LAST: begin
                    position_next     = POS_HEADER;
                    frame_valid_next  = 1'b1;
                    frame_next.enabled = (enable_reg == FLAG_ON);
                    frame_next.x_raw  = {sample_reg[1], sample_reg[0][BYTE_W-1:BYTE_W/2]};
                    frame_next.y_raw  = {sample_reg[3], sample_reg[2][BYTE_W-1:BYTE_W/2]};
                    frame_next.z_raw  = {s_rx_byte, sample_reg[4][BYTE_W-1:BYTE_W/2]};
                end
                default: begin
                    sample_write  = 1'b1;
                    position_next = position_reg + 3'd1;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg    <= POS_HEADER;
            enable_reg      <= '0;
            frame_valid_reg <= 1'b0;
        end else begin
            position_reg    <= position_next;
            enable_reg      <= enable_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    // Payload: the decoded frame and the sample buffer.
    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            if (sample_write && (sample_idx == 3'(i))) begin
                sample_reg[i] <= s_rx_byte;
            end
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/afd_axis_scaler.sv =====
`default_nettype none

module afd_axis_scaler (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              frame_valid,
    input  wire afd_pkg::afd_frame_t               frame,
    output logic                                   frame_ready,
    input  wire logic [afd_pkg::SCALE_W-1:0]       scale_q16,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [afd_pkg::ACCEL_W-1:0]     m_x_accel,
    output logic signed [afd_pkg::ACCEL_W-1:0]     m_y_accel,
    output logic signed [afd_pkg::ACCEL_W-1:0]     m_z_accel,
    output logic                                   m_sensor_enabled
);
    import afd_pkg::*;

    logic                      m_valid_reg, m_valid_next;
    logic signed [ACCEL_W-1:0] x_reg, x_next;
    logic signed [ACCEL_W-1:0] y_reg, y_next;
    logic signed [ACCEL_W-1:0] z_reg, z_next;
    logic                      enabled_reg, enabled_next;

    logic signed [SCALE_W:0]   scale_s;
    logic signed [PROD_W-1:0]  prod_x, prod_y, prod_z;
    logic                      load;

    // The result register accepts a frame when empty or when its beat is taken.
    assign frame_ready = !m_valid_reg || m_ready;
    assign load        = frame_valid && frame_ready;

    // Three independent signed multiplies by the unsigned scale.
    assign scale_s = $signed({1'b0, scale_q16});
    assign prod_x  = $signed(frame.x_raw) * scale_s;
    assign prod_y  = $signed(frame.y_raw) * scale_s;
    assign prod_z  = $signed(frame.z_raw) * scale_s;

    // A disabled frame yields zero on all axes.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        enabled_next = enabled_reg;
        if (load) begin
            m_valid_next = 1'b1;
            enabled_next = frame.enabled;
            if (frame.enabled) begin
                x_next = prod_x[ACCEL_W-1:0];
                y_next = prod_y[ACCEL_W-1:0];
                z_next = prod_z[ACCEL_W-1:0];
            end else begin
                x_next = '0;
                y_next = '0;
                z_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        enabled_reg <= enabled_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_x_accel        = x_reg;
    assign m_y_accel        = y_reg;
    assign m_z_accel        = z_reg;
    assign m_sensor_enabled = enabled_reg;

endmodule

`default_nettype wire
